/* hw/rtl/jse_pkg.sv */
package jse_pkg;

  // configuration register
  localparam int CFG_W = 13;
  localparam logic [CFG_W-1:0] CAP_RESET = 13'd384;
  localparam int MAX_CAPACITY_DEFAULT = 4096;

  // control bytes below this value that have no short escape need a unicode escape
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  // characters used in escapes
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_FF        = 8'h0C;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LOW_B     = 8'h62;
  localparam logic [7:0] CH_LOW_F     = 8'h66;
  localparam logic [7:0] CH_LOW_N     = 8'h6E;
  localparam logic [7:0] CH_LOW_R     = 8'h72;
  localparam logic [7:0] CH_LOW_T     = 8'h74;
  localparam logic [7:0] CH_LOW_U     = 8'h75;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_TERM      = 8'h00;

  // depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // kind of output sequence one request expands into
  typedef enum logic [1:0] {
    JOB_ONE  = 2'd0,
    JOB_TWO  = 2'd1,
    JOB_SIX  = 2'd2,
    JOB_TERM = 2'd3
  } job_kind_t;

  // one queued job: for JOB_TWO data holds the escape letter,
  // for JOB_ONE and JOB_SIX the raw byte
  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] data;
    logic       status;
  } job_t;

  // lowercase hex digit
  function automatic logic [7:0] hex_lower(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = CH_ZERO + {4'd0, nib};
    end else begin
      ch = 8'h57 + {4'd0, nib};
    end
    return ch;
  endfunction

endpackage

/* hw/rtl/jse_queue.sv */
module jse_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  jse_pkg::job_t  push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output jse_pkg::job_t  head
);

  localparam int PTR_W = $clog2(jse_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(jse_pkg::QUEUE_DEPTH + 1);

  jse_pkg::job_t entries [jse_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(jse_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* hw/rtl/jse_front.sv */
module jse_front #(
  parameter int MAX_CAPACITY = jse_pkg::MAX_CAPACITY_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [jse_pkg::CFG_W-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               char_byte,
  input  logic                     string_end,
  input  logic                     queue_full,
  output logic                     push,
  output jse_pkg::job_t            push_job
);

  localparam int CNT_W = (MAX_CAPACITY > 2) ? $clog2(MAX_CAPACITY) : 1;
  localparam int CAP_W = $clog2(MAX_CAPACITY + 1);
  localparam int SUM_W = ((CAP_W > jse_pkg::CFG_W) ? CAP_W : jse_pkg::CFG_W) + 1;

  logic [jse_pkg::CFG_W-1:0] out_capacity;
  logic [CNT_W-1:0]          bytes_used;
  logic                      overflowed;

  logic                      take;
  jse_pkg::job_kind_t        kind;
  logic [7:0]                esc;
  logic [2:0]                seq_len;
  logic [SUM_W-1:0]          cap;
  logic [SUM_W-1:0]          sum;
  logic                      fits;

  assign in_ready = !queue_full;
  assign take     = in_valid && in_ready;

  // classify the byte
  always_comb begin
    esc = 8'd0;
    unique case (char_byte)
      jse_pkg::CH_QUOTE:     esc = jse_pkg::CH_QUOTE;
      jse_pkg::CH_BACKSLASH: esc = jse_pkg::CH_BACKSLASH;
      jse_pkg::CH_BS:        esc = jse_pkg::CH_LOW_B;
      jse_pkg::CH_FF:        esc = jse_pkg::CH_LOW_F;
      jse_pkg::CH_LF:        esc = jse_pkg::CH_LOW_N;
      jse_pkg::CH_CR:        esc = jse_pkg::CH_LOW_R;
      jse_pkg::CH_TAB:       esc = jse_pkg::CH_LOW_T;
      default:               esc = 8'd0;
    endcase
    if (esc != 8'd0) begin
      kind    = jse_pkg::JOB_TWO;
      seq_len = 3'd2;
    end else if (char_byte < jse_pkg::CTRL_LIMIT) begin
      kind    = jse_pkg::JOB_SIX;
      seq_len = 3'd6;
    end else begin
      kind    = jse_pkg::JOB_ONE;
      seq_len = 3'd1;
    end
  end

  // fit test against the saturated capacity
  always_comb begin
    if (SUM_W'(out_capacity) > SUM_W'(MAX_CAPACITY)) begin
      cap = SUM_W'(MAX_CAPACITY);
    end else begin
      cap = SUM_W'(out_capacity);
    end
    sum  = SUM_W'(bytes_used) + SUM_W'(seq_len);
    fits = (sum < cap);
  end

  // job for the back end
  always_comb begin
    push            = 1'b0;
    push_job.kind   = kind;
    push_job.data   = (kind == jse_pkg::JOB_TWO) ? esc : char_byte;
    push_job.status = 1'b0;
    if (take) begin
      if (string_end) begin
        push            = 1'b1;
        push_job.kind   = jse_pkg::JOB_TERM;
        push_job.status = overflowed || (cap == '0);
      end else if (!overflowed && fits) begin
        push = 1'b1;
      end
    end
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= jse_pkg::CAP_RESET;
    end else if (cfg_we) begin
      out_capacity <= cfg_data;
    end
  end

  // running count and sticky overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_used <= '0;
      overflowed <= 1'b0;
    end else if (take) begin
      if (string_end) begin
        bytes_used <= '0;
        overflowed <= 1'b0;
      end else if (!overflowed) begin
        if (fits) begin
          bytes_used <= sum[CNT_W-1:0];
        end else begin
          overflowed <= 1'b1;
        end
      end
    end
  end

endmodule

/* hw/rtl/jse_back.sv */
module jse_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          queue_empty,
  input  jse_pkg::job_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_char,
  output logic          is_terminator,
  output logic          escape_status,
  output logic          last_of_run
);

  logic [2:0] step;
  logic [2:0] last_step;
  logic       load;
  logic       at_last;
  logic [7:0] byte_sel;

  logic [7:0] out_char_r;
  logic       is_term_r;
  logic       status_r;
  logic       last_r;

  assign load    = (!out_valid || out_ready) && !queue_empty;
  assign at_last = (step == last_step);
  assign pop     = load && at_last;

  // last step of the head job (sequence length minus one)
  always_comb begin
    unique case (head.kind)
      jse_pkg::JOB_TWO: last_step = 3'd1;
      jse_pkg::JOB_SIX: last_step = 3'd5;
      default:          last_step = 3'd0;
    endcase
  end

  // pick the byte at the current step
  always_comb begin
    byte_sel = head.data;
    unique case (head.kind)
      jse_pkg::JOB_TWO: begin
        byte_sel = (step == 3'd0) ? jse_pkg::CH_BACKSLASH : head.data;
      end
      jse_pkg::JOB_SIX: begin
        case (step)
          3'd0:    byte_sel = jse_pkg::CH_BACKSLASH;
          3'd1:    byte_sel = jse_pkg::CH_LOW_U;
          3'd2:    byte_sel = jse_pkg::CH_ZERO;
          3'd3:    byte_sel = jse_pkg::CH_ZERO;
          3'd4:    byte_sel = jse_pkg::hex_lower(head.data[7:4]);
          default: byte_sel = jse_pkg::hex_lower(head.data[3:0]);
        endcase
      end
      jse_pkg::JOB_TERM: byte_sel = jse_pkg::CH_TERM;
      default:           byte_sel = head.data;
    endcase
  end

  // step counter within the current job
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 3'd0;
    end else if (load) begin
      step <= at_last ? 3'd0 : step + 3'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char_r <= byte_sel;
      is_term_r  <= (head.kind == jse_pkg::JOB_TERM);
      status_r   <= (head.kind == jse_pkg::JOB_TERM) && head.status;
      last_r     <= at_last;
    end
  end

  assign out_char      = out_char_r;
  assign is_terminator = is_term_r;
  assign escape_status = status_r;
  assign last_of_run   = last_r;

endmodule

/* hw/rtl/json_string_escaper_unit.sv */
// JSON string escaper. Input requests carry one raw byte each (or an end mark);
// output requests carry one escaped byte each, with the terminator (0x00) and
// an ok/overflow status closing every string. The front takes one input
// request per cycle while its four-entry job queue has room; the back emits
// one output byte per cycle while out_ready is high and a job is queued, so a
// plain byte becomes 1 output byte, a quote, backslash or short control escape
// 2 bytes and a \u00xx escape 6 bytes, and the output register sets the
// sustained rate. The first output byte passes through the job queue and the
// output register. Bytes that do not fit the capacity (one place kept for the
// terminator) set a sticky overflow and, like every later byte of that string,
// are dropped without output. out_capacity is written through cfg_we/cfg_data
// and is used saturated at MAX_CAPACITY; write it only while the block is idle.
module json_string_escaper_unit #(
  parameter int MAX_CAPACITY = jse_pkg::MAX_CAPACITY_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [jse_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                char_byte,
  input  logic                      string_end,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_char,
  output logic                      is_terminator,
  output logic                      escape_status,
  output logic                      last_of_run
);

  logic          push;
  jse_pkg::job_t push_job;
  logic          queue_full;
  logic          queue_empty;
  logic          pop;
  jse_pkg::job_t head;

  // classify and account
  jse_front #(
    .MAX_CAPACITY(MAX_CAPACITY)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_byte  (char_byte),
    .string_end (string_end),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  // job queue
  jse_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (queue_full),
    .pop      (pop),
    .empty    (queue_empty),
    .head     (head)
  );

  // expand jobs into bytes
  jse_back u_back (
    .clk           (clk),
    .rst           (rst),
    .queue_empty   (queue_empty),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char      (out_char),
    .is_terminator (is_terminator),
    .escape_status (escape_status),
    .last_of_run   (last_of_run)
  );

endmodule
